/* sv/fed_pkg.sv */
// shared constants, register codes and types of the feedback echo delay block
package fed_pkg;

  // default sizing of the block
  localparam int CHANNELS_DEF    = 2;
  localparam int MAX_DELAY_DEF   = 32768;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration word layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // q1.15 gains: 17 bits hold unity
  localparam int GAIN_W     = 17;
  localparam int GAIN_ONE   = 32768;
  localparam int Q_SHIFT    = 15;
  localparam int ROUND_HALF = 16384;

  // register values after reset
  localparam int DELAY_RESET = 22050;
  localparam int GAIN_RESET  = 16384;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET      = 2'd2
  } cfg_reg_t;

  // gain settings handed to the datapath, already limited to unity
  typedef struct packed {
    logic [CFG_DATA_W-1:0] feedback;
    logic [CFG_DATA_W-1:0] wet;
  } gains_t;

endpackage

/* sv/fed_in_if.sv */
// input sample channel: channel number and sample word
interface fed_in_if #(
  parameter int CH_W        = 1,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [CH_W-1:0]               channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

/* sv/fed_out_if.sv */
// result channel: channel number and mixed sample word
interface fed_out_if #(
  parameter int CH_W        = 1,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [CH_W-1:0]               channel_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

/* sv/fed_cfg_if.sv */
// configuration write channel: register index and write data
interface fed_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fed_pkg::CFG_IDX_W-1:0]   index;
  logic [fed_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/fed_ram.sv */
// generic single-write, single-read ram with registered read data (read-first)
module fed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/fed_dsp.sv */
// gain products, rounding and saturation for the mix and the feedback word
module fed_dsp #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  fed_pkg::gains_t               gains,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] delayed,
  output logic signed [SAMPLE_BITS-1:0] mix,
  output logic signed [SAMPLE_BITS-1:0] fb
);

  localparam int GW     = fed_pkg::GAIN_W;
  localparam int PROD_W = SAMPLE_BITS + GW + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = SUM_W - fed_pkg::Q_SHIFT + 1;
  localparam logic signed [RES_W-1:0] SMAX =
    {{(RES_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SMIN =
    {{(RES_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic [GW-1:0]                 dry_gain;
  logic signed [GW:0]            dry_s;
  logic signed [GW:0]            wet_s;
  logic signed [GW:0]            fbg_s;
  logic signed [PROD_W-1:0]      p_dry_r;
  logic signed [PROD_W-1:0]      p_wet_r;
  logic signed [PROD_W-1:0]      p_fb_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SUM_W-1:0]       mix_sum;
  logic signed [SUM_W-1:0]       fb_sum;
  logic signed [RES_W-1:0]       mix_full;
  logic signed [RES_W-1:0]       fb_full;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [RES_W-1:0] v);
    if (v > SMAX) begin
      return SMAX[SAMPLE_BITS-1:0];
    end else if (v < SMIN) begin
      return SMIN[SAMPLE_BITS-1:0];
    end else begin
      return v[SAMPLE_BITS-1:0];
    end
  endfunction

  // dry gain is unity minus wet, gains as positive signed operands
  assign dry_gain = GW'(fed_pkg::GAIN_ONE) - GW'(gains.wet);
  assign dry_s    = $signed({1'b0, dry_gain});
  assign wet_s    = $signed({2'b00, gains.wet});
  assign fbg_s    = $signed({2'b00, gains.feedback});

  // product stage
  always_ff @(posedge clk) begin
    p_dry_r <= PROD_W'(dry_s) * PROD_W'(x);
    p_wet_r <= PROD_W'(wet_s) * PROD_W'(delayed);
    p_fb_r  <= PROD_W'(fbg_s) * PROD_W'(delayed);
    x_r     <= x;
  end

  // round half up, then saturate
  assign mix_sum  = SUM_W'(p_dry_r) + SUM_W'(p_wet_r) + SUM_W'(fed_pkg::ROUND_HALF);
  assign fb_sum   = SUM_W'(p_fb_r) + SUM_W'(fed_pkg::ROUND_HALF);
  assign mix_full = RES_W'($signed(mix_sum[SUM_W-1:fed_pkg::Q_SHIFT]));
  assign fb_full  = RES_W'($signed(fb_sum[SUM_W-1:fed_pkg::Q_SHIFT])) + RES_W'(x_r);
  assign mix      = sat(mix_full);
  assign fb       = sat(fb_full);

endmodule

/* sv/feedback_echo_delay_core.sv */
// top level of the multichannel feedback echo delay
// The input is not ready while the last word taken is in the read-data stage; a result passes
// the read-data and result stages and waits in a two-word output queue, so the input keeps
// running while the consumer stalls briefly. This input limit comes from the single delay ram:
// each word reads its slot when taken and writes the feedback value back to that slot from the
// result stage; a write landing on the slot being read is forwarded. All channels share the ram,
// one region of MAX_DELAY words per channel. Writing the delay register resets every channel's
// position and marks its region empty, so old samples read as zero until the channel has gone
// once round its delay; no clearing pass is run and the block is ready right after reset.
// Gains are q1.15 with 32768 as unity; larger values are held at unity, a delay of zero acts as
// one and a delay above MAX_DELAY acts as MAX_DELAY.
module feedback_echo_delay_core #(
  parameter int CHANNELS    = fed_pkg::CHANNELS_DEF,
  parameter int MAX_DELAY   = fed_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  fed_in_if.sink   in_port,
  fed_out_if.source out_port,
  fed_cfg_if.sink  cfg_port
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = $clog2(MAX_DELAY);
  localparam int LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int DW     = fed_pkg::CFG_DATA_W;
  localparam int CMP_W  = (LEN_W > DW) ? LEN_W : DW;
  localparam int DEPTH  = CHANNELS * MAX_DELAY;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [LEN_W-1:0]      delay_len_r;
  fed_pkg::gains_t       gains_r;
  logic                  cfg_fire;
  logic                  delay_we;
  logic                  fbg_we;
  logic                  wet_we;

  // per-channel position and filled mark
  logic [POS_W-1:0]      pos_r [CHANNELS];
  logic [CHANNELS-1:0]   filled_r;

  // accept side
  logic                  in_fire;
  logic                  in_range;
  logic [POS_W-1:0]      pos_sel;
  logic [LEN_W-1:0]      pos_inc;
  logic                  wrap;
  logic [ADDR_W-1:0]     addr_a;

  // read-data stage
  logic                  b_valid_r;
  logic [CH_W-1:0]       b_ch_r;
  logic                  b_in_range_r;
  logic                  b_hit_r;
  logic [ADDR_W-1:0]     b_addr_r;
  logic signed [SAMPLE_BITS-1:0] b_x_r;
  logic signed [SAMPLE_BITS-1:0] delayed_b;

  // result stage
  logic                  c_valid_r;
  logic [CH_W-1:0]       c_ch_r;
  logic                  c_in_range_r;
  logic [ADDR_W-1:0]     c_addr_r;
  logic signed [SAMPLE_BITS-1:0] mix_c;
  logic signed [SAMPLE_BITS-1:0] fb_c;

  // ram and forwarding of the last write
  logic                  ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                  lw_valid_r;
  logic [ADDR_W-1:0]     lw_addr_r;
  logic [SAMPLE_BITS-1:0] lw_data_r;

  // output queue
  logic [CH_W-1:0]       q_ch_r  [2];
  logic [SAMPLE_BITS-1:0] q_smp_r [2];
  logic                  q_wr_r;
  logic                  q_rd_r;
  logic [1:0]            q_cnt_r;
  logic                  q_pop;
  logic [2:0]            inflight;

  function automatic logic [LEN_W-1:0] clamp_delay(input logic [DW-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) begin
      return LEN_W'(1);
    end else if (w > CMP_W'(MAX_DELAY)) begin
      return LEN_W'(MAX_DELAY);
    end else begin
      return LEN_W'(w);
    end
  endfunction

  function automatic logic [DW-1:0] clamp_gain(input logic [DW-1:0] v);
    if (v > DW'(fed_pkg::GAIN_ONE)) begin
      return DW'(fed_pkg::GAIN_ONE);
    end else begin
      return v;
    end
  endfunction

  // register decode
  assign cfg_port.ready = 1'b1;
  assign cfg_fire = cfg_port.valid && cfg_port.ready;

  always_comb begin
    delay_we = 1'b0;
    fbg_we   = 1'b0;
    wet_we   = 1'b0;
    unique case (cfg_port.index)
      fed_pkg::REG_DELAY:    delay_we = cfg_fire;
      fed_pkg::REG_FEEDBACK: fbg_we   = cfg_fire;
      fed_pkg::REG_WET:      wet_we   = cfg_fire;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_len_r      <= clamp_delay(DW'(fed_pkg::DELAY_RESET));
      gains_r.feedback <= DW'(fed_pkg::GAIN_RESET);
      gains_r.wet      <= DW'(fed_pkg::GAIN_RESET);
    end else begin
      if (delay_we) begin
        delay_len_r <= clamp_delay(cfg_port.data);
      end
      if (fbg_we) begin
        gains_r.feedback <= clamp_gain(cfg_port.data);
      end
      if (wet_we) begin
        gains_r.wet <= clamp_gain(cfg_port.data);
      end
    end
  end

  // input handshake: one word in flight per ram slot turn, queue space reserved
  assign inflight = {2'b00, b_valid_r} + {2'b00, c_valid_r} + {1'b0, q_cnt_r};
  assign in_port.ready = !b_valid_r && (inflight < 3'd2);
  assign in_fire = in_port.valid && in_port.ready;

  // slot selection for the incoming word
  assign in_range = ({1'b0, in_port.channel} < (CH_W + 1)'(CHANNELS));
  assign pos_sel  = in_range ? pos_r[in_port.channel] : '0;
  assign pos_inc  = LEN_W'(pos_sel) + LEN_W'(1);
  assign wrap     = (pos_inc >= delay_len_r);
  assign addr_a   = ADDR_W'(ADDR_W'(in_port.channel) * ADDR_W'(MAX_DELAY)) + ADDR_W'(pos_sel);

  // position advance; a delay write resets every channel
  always_ff @(posedge clk) begin
    if (!rst_n || delay_we) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i] <= '0;
      end
      filled_r <= '0;
    end else if (in_fire && in_range) begin
      pos_r[in_port.channel] <= wrap ? '0 : POS_W'(pos_inc);
      if (wrap) begin
        filled_r[in_port.channel] <= 1'b1;
      end
    end
  end

  // read-data stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_ch_r       <= in_port.channel;
      b_in_range_r <= in_range;
      b_hit_r      <= in_range && filled_r[in_port.channel];
      b_addr_r     <= addr_a;
      b_x_r        <= in_port.sample_in;
    end
  end

  // delayed word: zero for an empty region or an out-of-range channel, forwarded when the slot was just written
  always_comb begin
    if (!b_hit_r) begin
      delayed_b = '0;
    end else if (lw_valid_r && (lw_addr_r == b_addr_r)) begin
      delayed_b = $signed(lw_data_r);
    end else begin
      delayed_b = $signed(ram_rdata);
    end
  end

  fed_dsp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dsp (
    .clk     (clk),
    .gains   (gains_r),
    .x       (b_x_r),
    .delayed (delayed_b),
    .mix     (mix_c),
    .fb      (fb_c)
  );

  // result stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      c_ch_r       <= b_ch_r;
      c_in_range_r <= b_in_range_r;
      c_addr_r     <= b_addr_r;
    end
  end

  // delay store and write-back
  assign ram_we = c_valid_r && c_in_range_r;

  fed_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_addr_r),
    .wdata (fb_c),
    .raddr (addr_a),
    .rdata (ram_rdata)
  );

  // last write, registered to cover a read at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else begin
      lw_valid_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      lw_addr_r <= c_addr_r;
      lw_data_r <= fb_c;
    end
  end

  // two-word output queue
  assign q_pop = out_port.valid && out_port.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (c_valid_r) begin
        q_wr_r <= !q_wr_r;
      end
      if (q_pop) begin
        q_rd_r <= !q_rd_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, c_valid_r} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid_r) begin
      q_ch_r[q_wr_r]  <= c_ch_r;
      q_smp_r[q_wr_r] <= mix_c;
    end
  end

  assign out_port.valid       = (q_cnt_r != 2'd0);
  assign out_port.channel_out = q_ch_r[q_rd_r];
  assign out_port.sample_out  = $signed(q_smp_r[q_rd_r]);

  // checks
  a_rate: assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_fire)
    else $error("input word taken in two consecutive cycles");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> (q_cnt_r < 2'd2) || q_pop)
    else $error("result pushed into a full output queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'd2)
    else $error("output queue count out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n) delay_we |=> filled_r == '0)
    else $error("delay write did not empty the delay regions");

endmodule

/* verif/feedback_echo_delay_core_test.sv */
// self-checking testbench of the feedback echo delay core: predicted words, random idling, stalls
module feedback_echo_delay_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W         = fed_pkg::SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX       = 32767;
  localparam int SAMPLE_MIN       = -32768;
  localparam int LIMIT_CYCLES     = 400000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int PHASE_WORDS      = 50;
  localparam int RANDOM_PHASES    = 11;
  localparam int PRESSURE_PHASE   = 4;
  localparam int QUIET_PHASE      = 2;

  // an index past the register list, dropped by the block
  localparam logic [fed_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    logic    ch;
    sample_t sample;
  } echo_word_t;

  // tracks the echo lines and holds the mixed words still to come
  class echo_scoreboard;
    int         delay_len;
    int         fb_gain;
    int         wet_gain;
    int         wpos [fed_pkg::CHANNELS_DEF];
    sample_t    echo_mem [int];
    echo_word_t due [$];
    int         failures;

    function new();
      delay_len = clamp_delay(fed_pkg::DELAY_RESET);
      fb_gain   = fed_pkg::GAIN_RESET;
      wet_gain  = fed_pkg::GAIN_RESET;
      failures  = 0;
      clear_lines();
    endfunction

    function int clamp_delay(int v);
      if (v == 0) return 1;
      if (v > fed_pkg::MAX_DELAY_DEF) return fed_pkg::MAX_DELAY_DEF;
      return v;
    endfunction

    function int clamp_gain(int v);
      return (v > fed_pkg::GAIN_ONE) ? fed_pkg::GAIN_ONE : v;
    endfunction

    // empty lines read as zero, positions back to the start
    function void clear_lines();
      echo_mem.delete();
      foreach (wpos[i]) wpos[i] = 0;
    endfunction

    // floor((v + half) / unity)
    function longint round_q15(longint v);
      return (v + fed_pkg::ROUND_HALF) >>> fed_pkg::Q_SHIFT;
    endfunction

    function sample_t saturate(longint v);
      if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
      return sample_t'(v);
    endfunction

    function void set_register(logic [fed_pkg::CFG_IDX_W-1:0] idx,
                               logic [fed_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fed_pkg::REG_DELAY: begin
          delay_len = clamp_delay(int'(data));
          clear_lines();
        end
        fed_pkg::REG_FEEDBACK: fb_gain = clamp_gain(int'(data));
        fed_pkg::REG_WET:      wet_gain = clamp_gain(int'(data));
        default: ;
      endcase
    endfunction

    // mix the word with its echo, write the feedback sum back, step the position
    function void note_input(logic ch, sample_t x);
      int         slot;
      sample_t    d;
      echo_word_t w;
      slot = int'(ch) * fed_pkg::MAX_DELAY_DEF + wpos[ch];
      d = echo_mem.exists(slot) ? echo_mem[slot] : sample_t'(0);
      w.ch = ch;
      w.sample = saturate(round_q15(longint'(fed_pkg::GAIN_ONE - wet_gain) * x
                                    + longint'(wet_gain) * d));
      due.insert(due.size(), w);
      echo_mem[slot] = saturate(longint'(x) + round_q15(longint'(fb_gain) * d));
      wpos[ch] = (wpos[ch] + 1 >= delay_len) ? 0 : wpos[ch] + 1;
    endfunction

    function void check_result(logic ch, sample_t s);
      echo_word_t w;
      if (due.size() == 0) begin
        $error("result word with none expected: channel_out %0d sample_out %0d", ch, s);
        failures++;
        return;
      end
      w = due.pop_front();
      if (ch !== w.ch) begin
        $error("channel_out mismatch: expected %0d, actual %0d", w.ch, ch);
        failures++;
      end
      if (s !== w.sample) begin
        $error("sample_out mismatch: expected %0d, actual %0d", w.sample, s);
        failures++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on;
  int   hold_requests;
  int   cycle_count;

  echo_scoreboard sb;

  fed_in_if  in_if ();
  fed_out_if out_if ();
  fed_cfg_if cfg_if ();

  feedback_echo_delay_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL feedback_echo_delay_core");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.channel_out, out_if.sample_out);
    end
  end

  // result side: random stall bursts, plus the long hold on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left = 0;
    holds_done = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = LONG_HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one sample word, with an optional idle burst ahead of it
  task automatic send_sample(logic ch, sample_t x);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.channel   <= ch;
    in_if.sample_in <= x;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    sb.note_input(ch, x);
  endtask

  task automatic write_register(logic [fed_pkg::CFG_IDX_W-1:0] idx,
                                logic [fed_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // stop offering and let every expected word come out, plus the write-back tail
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // mostly short delays so echoes come back within a phase
  function automatic logic [fed_pkg::CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return fed_pkg::CFG_DATA_W'(fed_pkg::MAX_DELAY_DEF);
      2:       return '1;
      3:       return fed_pkg::CFG_DATA_W'($urandom);
      default: return fed_pkg::CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [fed_pkg::CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return fed_pkg::CFG_DATA_W'(fed_pkg::GAIN_ONE);
      2:       return fed_pkg::CFG_DATA_W'($urandom_range(fed_pkg::GAIN_ONE + 1, 65535));
      default: return fed_pkg::CFG_DATA_W'($urandom_range(0, fed_pkg::GAIN_ONE));
    endcase
  endfunction

  initial begin : stimulus
    int p;
    int k;
    sb = new();
    rst_n = 1'b0;
    idle_on = 1'b1;
    hold_requests = 0;
    in_if.valid = 1'b0;
    in_if.channel = '0;
    in_if.sample_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = fed_pkg::REG_DELAY;
    cfg_if.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, lines empty: dry half of the mix and rounding of odd words
    send_sample(1'b0, sample_t'(SAMPLE_MAX));
    send_sample(1'b1, sample_t'(SAMPLE_MIN));
    send_sample(1'b0, sample_t'(0));
    send_sample(1'b1, sample_t'(-1));
    send_sample(1'b0, sample_t'(1));
    send_sample(1'b1, sample_t'(12345));
    drain();

    // zero delay acts as one, feedback above unity held at unity, fully wet: both rails
    write_register(fed_pkg::REG_DELAY, '0);
    write_register(fed_pkg::REG_FEEDBACK, '1);
    write_register(fed_pkg::REG_WET, fed_pkg::CFG_DATA_W'(fed_pkg::GAIN_ONE));
    repeat (3) send_sample(1'b0, sample_t'(SAMPLE_MAX));
    repeat (3) send_sample(1'b1, sample_t'(SAMPLE_MIN));
    drain();

    // write past the register list is dropped; dry only, no feedback
    write_register(REG_UNUSED, '1);
    write_register(fed_pkg::REG_WET, '0);
    write_register(fed_pkg::REG_FEEDBACK, '0);
    send_sample(1'b0, sample_t'(100));
    send_sample(1'b0, sample_t'(-200));
    drain();

    // wet just above unity reads back the stored word
    write_register(fed_pkg::REG_WET, fed_pkg::CFG_DATA_W'(fed_pkg::GAIN_ONE + 1));
    send_sample(1'b0, sample_t'(5));
    drain();

    // longest delay
    write_register(fed_pkg::REG_DELAY, fed_pkg::CFG_DATA_W'(fed_pkg::MAX_DELAY_DEF));
    send_sample(1'b1, sample_t'(-1));
    send_sample(1'b0, sample_t'(1));
    drain();

    // random phases; one quiet, one with a long output hold, the last ones with no idling
    for (p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != QUIET_PHASE && p != PRESSURE_PHASE && p < RANDOM_PHASES - 2);
      if ($urandom_range(0, 3) != 0) write_register(fed_pkg::REG_DELAY, pick_delay());
      write_register(fed_pkg::REG_FEEDBACK, pick_gain());
      write_register(fed_pkg::REG_WET, pick_gain());
      if (p == PRESSURE_PHASE) hold_requests++;
      for (k = 0; k < PHASE_WORDS; k++) begin
        send_sample(1'($urandom_range(0, 1)), pick_sample());
      end
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS feedback_echo_delay_core");
    end else begin
      $display("FAIL feedback_echo_delay_core");
    end
    $finish;
  end

endmodule

/* files.f */
sv/fed_pkg.sv
sv/fed_in_if.sv
sv/fed_out_if.sv
sv/fed_cfg_if.sv
sv/fed_ram.sv
sv/fed_dsp.sv
sv/feedback_echo_delay_core.sv
verif/feedback_echo_delay_core_test.sv
